@@ rtl/p448_pkg.sv @@
// Shared constants and item type for the p448 field multiplier.
package p448_pkg;

    localparam int LIMB_BITS   = 28;
    localparam int HALF_LIMBS  = 8;
    localparam int NUM_LIMBS   = 2 * HALF_LIMBS;
    localparam int IDX_W       = 4;
    localparam int IN_W        = 30;
    localparam int OUT_W       = 29;
    localparam int PROD_W      = 2 * IN_W;
    localparam int ACC_W       = 64;
    localparam int CHAIN_W     = ACC_W - LIMB_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LIMBS - 1);

    // one loaded limb pair as it travels from front to back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [IN_W-1:0]  a;
        logic [IN_W-1:0]  b;
        logic             trig;
    } t_item;

endpackage

@@ rtl/p448_front.sv @@
// Front end: accepts limb pairs, flags the triggering limb, queues items.
module p448_front
    import p448_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IDX_W-1:0] i_limb_index,
    input  logic [IN_W-1:0]  i_a_limb,
    input  logic [IN_W-1:0]  i_b_limb,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  logic             i_q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_q [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;
    t_item            n_item;

    // classify the incoming limb pair
    always_comb begin
        n_item.idx  = i_limb_index;
        n_item.a    = i_a_limb;
        n_item.b    = i_b_limb;
        n_item.trig = (i_limb_index == LAST_IDX);
    end

    assign busy      = (r_cnt == CNT_FULL);
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    // store queued items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

@@ rtl/p448_back.sv @@
// Back end: limb stores, column multiply-accumulate, carry chains, emit.
module p448_back
    import p448_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_strobe,
    output logic [IDX_W-1:0] o_out_index,
    output logic [OUT_W-1:0] o_product_limb,
    output logic             o_last_limb
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [1:0] W_ZERO = 2'd0;
    localparam logic [1:0] W_ONE  = 2'd1;
    localparam logic [1:0] W_TWO  = 2'd2;

    localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(HALF_LIMBS);

    logic [IN_W-1:0]      r_a_mem [NUM_LIMBS];
    logic [IN_W-1:0]      r_b_mem [NUM_LIMBS];
    logic [LIMB_BITS-1:0] r_p_mem [NUM_LIMBS];

    logic [2:0]       r_state;
    logic [IDX_W-1:0] r_i, r_c, r_oi;

    // issue stage signals
    logic [IDX_W-1:0] j1, j2;
    logic [IDX_W:0]   k1, k2;
    logic [1:0]       w1, w2;

    logic             r_s1_v, r_s1_first, r_s1_last;
    logic [IDX_W-1:0] r_s1_col;
    logic [1:0]       r_s1_w1, r_s1_w2;
    logic [IN_W-1:0]  r_s1_a, r_s1_b1, r_s1_b2;

    logic             r_s2_v, r_s2_first, r_s2_last;
    logic [IDX_W-1:0] r_s2_col;
    logic [1:0]       r_s2_w1, r_s2_w2;
    logic [PROD_W-1:0] r_s2_p1, r_s2_p2;

    logic [PROD_W:0]  t1, t2;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_tot_v;
    logic [IDX_W-1:0] r_tot_col;

    logic [CHAIN_W-1:0] r_chain_lo, r_chain_hi, chain_sel;
    logic [ACC_W-1:0]   col_sum;
    logic [LIMB_BITS-1:0] col_limb;

    logic [OUT_W-1:0] r_l0, r_l1, r_l8, r_l9;
    logic [CHAIN_W+1:0] t8, t0;

    logic             r_q_v;
    logic [IDX_W-1:0] r_q_idx;
    logic [OUT_W-1:0] r_q_limb;

    logic pop;

    assign o_q_pop = (r_state == ST_IDLE);
    assign pop     = o_q_pop && i_q_valid;

    // pick b indices and fold weights for column r_c, row r_i
    always_comb begin
        j1 = r_c - r_i;
        j2 = r_c + IDX_HALF - r_i;
        k1 = {1'b0, r_i} + {1'b0, j1};
        k2 = {1'b0, r_i} + {1'b0, j2};
        w1 = !k1[IDX_W] ? W_ONE : (r_c[IDX_W-1] ? W_TWO : W_ONE);
        w2 = k2[IDX_W] ? W_ONE : W_ZERO;
    end

    // write limb stores, read operands for the multiplier
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_a_mem[i_q_item.idx] <= i_q_item.a;
            r_b_mem[i_q_item.idx] <= i_q_item.b;
        end
        r_s1_a     <= r_a_mem[r_i];
        r_s1_b1    <= r_b_mem[j1];
        r_s1_b2    <= r_b_mem[j2];
        r_s1_first <= (r_i == '0);
        r_s1_last  <= (r_i == LAST_IDX);
        r_s1_col   <= r_c;
        r_s1_w1    <= w1;
        r_s1_w2    <= w2;
    end

    // multiply both pairs
    always_ff @(posedge i_clk) begin
        r_s2_p1    <= r_s1_a * r_s1_b1;
        r_s2_p2    <= r_s1_a * r_s1_b2;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_col   <= r_s1_col;
        r_s2_w1    <= r_s1_w1;
        r_s2_w2    <= r_s1_w2;
    end

    // weight products and accumulate the column
    always_comb begin
        unique case (r_s2_w1)
            W_TWO:   t1 = {r_s2_p1, 1'b0};
            W_ONE:   t1 = {1'b0, r_s2_p1};
            default: t1 = '0;
        endcase
        unique case (r_s2_w2)
            W_TWO:   t2 = {r_s2_p2, 1'b0};
            W_ONE:   t2 = {1'b0, r_s2_p2};
            default: t2 = '0;
        endcase
        n_acc = (r_s2_first ? '0 : r_acc) + ACC_W'(t1) + ACC_W'(t2);
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_acc <= n_acc;
        end
        r_tot_col <= r_s2_col;
    end

    // carry step on a finished column
    always_comb begin
        chain_sel = r_tot_col[IDX_W-1] ? r_chain_hi : r_chain_lo;
        col_sum   = r_acc + ACC_W'(chain_sel);
        col_limb  = col_sum[LIMB_BITS-1:0];
        t8 = (CHAIN_W+2)'(r_chain_lo) + (CHAIN_W+2)'(r_chain_hi) + (CHAIN_W+2)'(r_l8);
        t0 = (CHAIN_W+2)'(r_chain_hi) + (CHAIN_W+2)'(r_l0);
    end

    always_ff @(posedge i_clk) begin
        if (r_tot_v) begin
            r_p_mem[r_tot_col] <= col_limb;
        end
    end

    // hold limbs 0, 1, 8 and 9 for the wrap-back fix
    always_ff @(posedge i_clk) begin
        if (r_tot_v) begin
            if (r_tot_col == 4'd0) r_l0 <= OUT_W'(col_limb);
            if (r_tot_col == 4'd1) r_l1 <= OUT_W'(col_limb);
            if (r_tot_col == IDX_HALF) r_l8 <= OUT_W'(col_limb);
            if (r_tot_col == IDX_HALF + 4'd1) r_l9 <= OUT_W'(col_limb);
        end else if (r_state == ST_FIX) begin
            r_l8 <= OUT_W'(t8[LIMB_BITS-1:0]);
            r_l0 <= OUT_W'(t0[LIMB_BITS-1:0]);
            r_l9 <= r_l9 + OUT_W'(t8[CHAIN_W+1:LIMB_BITS]);
            r_l1 <= r_l1 + OUT_W'(t0[CHAIN_W+1:LIMB_BITS]);
        end
    end

    // read product limbs for output
    always_ff @(posedge i_clk) begin
        r_q_limb <= OUT_W'(r_p_mem[r_oi]);
        r_q_idx  <= r_oi;
    end

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_i        <= '0;
            r_c        <= '0;
            r_oi       <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_tot_v    <= 1'b0;
            r_q_v      <= 1'b0;
            r_chain_lo <= '0;
            r_chain_hi <= '0;
        end else begin
            r_s1_v  <= (r_state == ST_RUN);
            r_s2_v  <= r_s1_v;
            r_tot_v <= r_s2_v && r_s2_last;
            r_q_v   <= (r_state == ST_EMIT);
            if (r_tot_v) begin
                if (r_tot_col[IDX_W-1]) begin
                    r_chain_hi <= col_sum[ACC_W-1:LIMB_BITS];
                end else begin
                    r_chain_lo <= col_sum[ACC_W-1:LIMB_BITS];
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (pop && i_q_item.trig) begin
                        r_state    <= ST_RUN;
                        r_i        <= '0;
                        r_c        <= '0;
                        r_chain_lo <= '0;
                        r_chain_hi <= '0;
                    end
                end
                ST_RUN: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST_IDX) begin
                        r_c <= r_c + 1'b1;
                        if (r_c == LAST_IDX) begin
                            r_state <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    if (r_tot_v && r_tot_col == LAST_IDX) begin
                        r_state <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    r_state <= ST_EMIT;
                    r_oi    <= '0;
                end
                ST_EMIT: begin
                    r_oi <= r_oi + 1'b1;
                    if (r_oi == LAST_IDX) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // drive result ports
    always_comb begin
        o_strobe    = r_q_v;
        o_out_index = r_q_idx;
        o_last_limb = r_q_v && (r_q_idx == LAST_IDX);
        if (r_q_idx == 4'd0) begin
            o_product_limb = r_l0;
        end else if (r_q_idx == 4'd1) begin
            o_product_limb = r_l1;
        end else if (r_q_idx == IDX_HALF) begin
            o_product_limb = r_l8;
        end else if (r_q_idx == IDX_HALF + 4'd1) begin
            o_product_limb = r_l9;
        end else begin
            o_product_limb = r_q_limb;
        end
    end

endmodule

@@ rtl/p448_field_multiplier.sv @@
// Top level of the p448 field multiplier: front queue and back engine.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | start / busy         | i_limb_index, i_a_limb, i_b_limb
//   result   | o_strobe (no stall)  | o_out_index, o_product_limb, o_last_limb
//
// A load item is written into the queue register and is popped from it while no product runs.
// The item with limb index 15 starts the product: it passes the queue, then the
// 16 columns x 16 rows run on one pair of 30x30 multipliers, the pipeline drains,
// the wrap-back fix and the limb read follow, and the 16 result limbs are emitted.
// Synchronous active-low reset clears control state; stores are not cleared.
// The queue keeps taking items during a product until it is full, then busy holds.
module p448_field_multiplier
    import p448_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IDX_W-1:0] i_limb_index,
    input  logic [IN_W-1:0]  i_a_limb,
    input  logic [IN_W-1:0]  i_b_limb,
    output logic             o_strobe,
    output logic [IDX_W-1:0] o_out_index,
    output logic [OUT_W-1:0] o_product_limb,
    output logic             o_last_limb
);

    logic  q_valid, q_pop;
    t_item q_item;

    p448_front #(
        .DEPTH(Q_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_limb_index(i_limb_index),
        .i_a_limb    (i_a_limb),
        .i_b_limb    (i_b_limb),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    p448_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_strobe      (o_strobe),
        .o_out_index   (o_out_index),
        .o_product_limb(o_product_limb),
        .o_last_limb   (o_last_limb)
    );

`ifndef SYNTHESIS
    // results come as one unbroken burst in index order
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_limb |=>
            o_strobe && o_out_index == $past(o_out_index) + 4'd1)
        else $error("result burst broken or out of order");

    // nothing follows the last limb directly
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_limb |=> !o_strobe)
        else $error("result after last limb");

    // a burst opens at limb zero
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> o_out_index == '0)
        else $error("burst does not start at limb zero");
`endif

endmodule
